FILE: design/ita_pkg.sv
// Shared types and constants for the integer-to-ASCII formatter.
package ita_pkg;

  // Number of decimal digits that a 32-bit magnitude can need.
  localparam int unsigned NumDigits = 10;
  // Binary-to-BCD conversion shifts in two bits per cycle.
  localparam int unsigned ConvSteps = 16;

  // ASCII codes used by the formatter.
  localparam logic [7:0] AsciiZero  = 8'h30;
  localparam logic [7:0] AsciiUpA   = 8'h41;
  localparam logic [7:0] AsciiX     = 8'h78;
  localparam logic [7:0] AsciiMinus = 8'h2D;
  localparam logic [7:0] AsciiSpace = 8'h20;

  // Mode codes.
  localparam logic [1:0] ModeDec    = 2'd0;
  localparam logic [1:0] ModeHexPfx = 2'd2;

  // Digit store: one nibble per digit, least significant digit at index 0.
  typedef logic [NumDigits-1:0][3:0] digits_t;

  // Which character the datapath puts out.
  typedef enum logic [2:0] {
    CH_ZERO,
    CH_X,
    CH_MINUS,
    CH_PAD,
    CH_DIGIT
  } char_kind_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;
    logic       step;
    logic       emit;
    char_kind_e kind;
    logic [3:0] idx;
  } ita_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic       prefix;
    logic       sign_pre;
    logic       sign_post;
    logic [3:0] num_digits;
    logic [5:0] width;
  } ita_status_t;

endpackage

FILE: design/ita_datapath.sv
// Datapath of the formatter: operand capture, binary-to-BCD conversion and character output.
module ita_datapath #(
  parameter int unsigned MAX_WIDTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ita_pkg::ita_cmd_t   cmd_i,
  input  logic [1:0]          mode_i,
  input  logic signed [31:0]  value_i,
  input  logic                zero_pad_i,
  input  logic [5:0]          field_width_i,
  output ita_pkg::ita_status_t status_o,
  output logic [7:0]          character_o
);

  localparam logic [5:0] MaxW = 6'(MAX_WIDTH);

  ita_pkg::digits_t dig_q, dig_d;
  logic [31:0]      mag_q, mag_d;
  logic             neg_q, zpad_q, prefix_q, dec_q;
  logic [5:0]       width_q;
  logic [7:0]       char_q;

  logic             in_neg;
  logic [31:0]      in_bits;
  logic [5:0]       w_clamp;
  logic [3:0]       nd;
  logic [3:0]       cur_dig;

  // Operand decode at load time.
  assign in_bits = value_i;
  assign in_neg  = (mode_i == ita_pkg::ModeDec) && in_bits[31];
  assign w_clamp = (field_width_i > MaxW) ? MaxW : field_width_i;

  // Two double-dabble steps per cycle: add three to large nibbles, then shift in one bit.
  always_comb begin
    logic [40:0] wide;
    dig_d = dig_q;
    mag_d = mag_q;
    for (int s = 0; s < 2; s++) begin
      for (int k = 0; k < ita_pkg::NumDigits; k++) begin
        if (dig_d[k] >= 4'd5) begin
          dig_d[k] = dig_d[k] + 4'd3;
        end
      end
      wide  = {dig_d, mag_d[31]};
      dig_d = wide[39:0];
      mag_d = {mag_d[30:0], 1'b0};
    end
  end

  // Operand and digit registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      dec_q    <= (mode_i == ita_pkg::ModeDec);
      prefix_q <= (mode_i == ita_pkg::ModeHexPfx);
      neg_q    <= in_neg;
      zpad_q   <= zero_pad_i;
      width_q  <= (in_neg && (w_clamp != 6'd0)) ? (w_clamp - 6'd1) : w_clamp;
      mag_q    <= in_neg ? (32'd0 - in_bits) : in_bits;
      if (mode_i == ita_pkg::ModeDec) begin
        dig_q <= '0;
      end else begin
        dig_q <= {8'd0, in_bits};
      end
    end else if (cmd_i.step) begin
      dig_q <= dig_d;
      mag_q <= mag_d;
    end
  end

  // Digit count: position of the highest nonzero digit, at least one.
  always_comb begin
    nd = 4'd1;
    for (int k = 1; k < ita_pkg::NumDigits; k++) begin
      if (dig_q[k] != 4'd0) begin
        nd = 4'(k + 1);
      end
    end
  end

  assign status_o.prefix     = prefix_q;
  assign status_o.sign_pre   = neg_q && zpad_q;
  assign status_o.sign_post  = neg_q && !zpad_q;
  assign status_o.num_digits = nd;
  assign status_o.width      = width_q;

  // Character register, loaded whenever the controller puts out a word.
  assign cur_dig = dig_q[cmd_i.idx];

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      case (cmd_i.kind)
        ita_pkg::CH_ZERO:  char_q <= ita_pkg::AsciiZero;
        ita_pkg::CH_X:     char_q <= ita_pkg::AsciiX;
        ita_pkg::CH_MINUS: char_q <= ita_pkg::AsciiMinus;
        ita_pkg::CH_PAD:   char_q <= (dec_q && !zpad_q) ? ita_pkg::AsciiSpace
                                                        : ita_pkg::AsciiZero;
        ita_pkg::CH_DIGIT: char_q <= (cur_dig < 4'd10)
                                       ? (ita_pkg::AsciiZero + {4'd0, cur_dig})
                                       : (ita_pkg::AsciiUpA + {4'd0, cur_dig} - 8'd10);
        default:           char_q <= ita_pkg::AsciiZero;
      endcase
    end
  end

  assign character_o = char_q;

  // A load and a conversion step are never commanded together.
  a_no_load_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.load && cmd_i.step)) else $error("load and step together");

  // The width held for printing never exceeds the clamp.
  a_width_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(cmd_i.load) |-> (width_q <= MaxW)) else $error("width above clamp");

  // Hex operands never use the top two digit slots.
  a_hex_digits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(cmd_i.load) && !dec_q |-> (dig_q[9] == 4'd0 && dig_q[8] == 4'd0))
    else $error("hex operand overflow");

endmodule

FILE: design/ita_controller.sv
// Controller of the formatter: sequences conversion and the order of the output words.
module ita_controller (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [1:0]           mode_i,
  input  ita_pkg::ita_status_t status_i,
  output ita_pkg::ita_cmd_t    cmd_o,
  output logic                 busy_o,
  output logic                 strobe_o,
  output logic                 last_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CONV,
    S_SETUP,
    S_PRE0,
    S_PRE1,
    S_SIGN_PRE,
    S_PAD,
    S_SIGN_POST,
    S_DIGITS
  } state_e;

  state_e     state_q, state_d;
  logic [3:0] cnt_q;
  logic [5:0] pad_q;
  logic [3:0] idx_q;
  logic       strobe_q, last_q;
  logic [5:0] pad_calc;
  logic       has_pad;
  logic       emit;

  // Padding needed once the digit count is known.
  assign pad_calc = (status_i.width > {2'd0, status_i.num_digits})
                  ? (status_i.width - {2'd0, status_i.num_digits}) : 6'd0;
  assign has_pad  = (state_q == S_SETUP) ? (pad_calc != 6'd0) : (pad_q != 6'd0);

  // Next section of the text after the current one, skipping empty sections.
  always_comb begin
    if (state_q == S_SETUP && status_i.prefix) begin
      state_d = S_PRE0;
    end else if (state_q == S_PRE0) begin
      state_d = S_PRE1;
    end else if ((state_q == S_SETUP || state_q == S_PRE1) && status_i.sign_pre) begin
      state_d = S_SIGN_PRE;
    end else if ((state_q == S_SETUP || state_q == S_PRE1 || state_q == S_SIGN_PRE)
                 && has_pad) begin
      state_d = S_PAD;
    end else if (state_q != S_SIGN_POST && status_i.sign_post) begin
      state_d = S_SIGN_POST;
    end else begin
      state_d = S_DIGITS;
    end
  end

  // Commands to the datapath.
  assign emit = (state_q == S_PRE0) || (state_q == S_PRE1) || (state_q == S_SIGN_PRE)
             || (state_q == S_PAD) || (state_q == S_SIGN_POST) || (state_q == S_DIGITS);

  always_comb begin
    cmd_o.load = (state_q == S_IDLE) && start_i;
    cmd_o.step = (state_q == S_CONV);
    cmd_o.emit = emit;
    cmd_o.idx  = idx_q;
    case (state_q)
      S_PRE0:      cmd_o.kind = ita_pkg::CH_ZERO;
      S_PRE1:      cmd_o.kind = ita_pkg::CH_X;
      S_SIGN_PRE:  cmd_o.kind = ita_pkg::CH_MINUS;
      S_SIGN_POST: cmd_o.kind = ita_pkg::CH_MINUS;
      S_PAD:       cmd_o.kind = ita_pkg::CH_PAD;
      default:     cmd_o.kind = ita_pkg::CH_DIGIT;
    endcase
  end

  // State, counters and registered output strobes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      pad_q    <= '0;
      idx_q    <= '0;
      strobe_q <= 1'b0;
      last_q   <= 1'b0;
    end else begin
      strobe_q <= emit;
      last_q   <= (state_q == S_DIGITS) && (idx_q == 4'd0);
      case (state_q)
        S_IDLE: begin
          cnt_q <= '0;
          if (start_i) begin
            state_q <= (mode_i == ita_pkg::ModeDec) ? S_CONV : S_SETUP;
          end
        end
        S_CONV: begin
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == 4'(ita_pkg::ConvSteps - 1)) begin
            state_q <= S_SETUP;
          end
        end
        S_SETUP: begin
          pad_q   <= pad_calc;
          idx_q   <= status_i.num_digits - 4'd1;
          state_q <= state_d;
        end
        S_PAD: begin
          pad_q <= pad_q - 6'd1;
          if (pad_q == 6'd1) begin
            state_q <= state_d;
          end
        end
        S_DIGITS: begin
          idx_q <= idx_q - 4'd1;
          if (idx_q == 4'd0) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= state_d;
        end
      endcase
    end
  end

  assign busy_o   = (state_q != S_IDLE);
  assign strobe_o = strobe_q;
  assign last_o   = last_q;

  // The last flag only comes with a word.
  a_last_has_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |-> strobe_o) else $error("last without strobe");

  // An accepted start always leaves the idle state.
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("start not taken");

  // After the last word the controller is idle again.
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && last_o) |-> !busy_o) else $error("busy after last word");

  // No word goes out during conversion.
  a_conv_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CONV) |-> !strobe_o) else $error("word during conversion");

endmodule

FILE: design/integer_to_ascii_formatter.sv
// Top level of the integer-to-ASCII formatter.
//
// Usage: drive mode_i, value_i, zero_pad_i and field_width_i and raise start_i.
// The operand is taken at a rising edge where start_i is high and busy_o is low.
// Text comes out one character per cycle on character_o, each word marked by
// strobe_o for exactly one cycle; last_o is high with the final character.
// Decimal operands first pass through a binary-to-BCD converter that shifts
// two bits a cycle; hex operands skip it. After the converter (decimal only)
// and a setup state, one character is sent every cycle. Decimal text is at
// most MAX_WIDTH characters (eleven, a sign and ten digits, when MAX_WIDTH
// is smaller) and hex text at most MAX_WIDTH + 2 (ten, when MAX_WIDTH is
// smaller than eight); this serial output and the converter set the rate.
// busy_o falls as the last character appears, so a new start can be taken
// in that same cycle.
// Reset (rst_ni low, asynchronous) returns the controller to idle and drops
// strobe_o; any text in progress is abandoned.
// The receiver cannot stall: every word must be taken when strobe_o is high.
module integer_to_ascii_formatter #(
  parameter int unsigned MAX_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         mode_i,
  input  logic signed [31:0] value_i,
  input  logic               zero_pad_i,
  input  logic [5:0]         field_width_i,
  output logic               strobe_o,
  output logic [7:0]         character_o,
  output logic               last_o
);

  ita_pkg::ita_cmd_t    cmd;
  ita_pkg::ita_status_t status;

  // Sequencing of conversion and output words.
  ita_controller u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .mode_i   (mode_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o),
    .strobe_o (strobe_o),
    .last_o   (last_o)
  );

  // Operand capture, digit conversion and character generation.
  ita_datapath #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .mode_i        (mode_i),
    .value_i       (value_i),
    .zero_pad_i    (zero_pad_i),
    .field_width_i (field_width_i),
    .status_o      (status),
    .character_o   (character_o)
  );

endmodule
